// ----- rtl/rtc_cal_pkg.sv -----
// Shared constants, types and calendar helpers for the framed command calendar clock.
package rtc_cal_pkg;

  // Frame buffer sizing
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] RX_DEPTH = 6'd32;
  localparam int HEAD_LEN = 10;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input event codes
  localparam logic [2:0] CMD_BYTE  = 3'd0;
  localparam logic [2:0] CMD_IDLE  = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_MODE  = 3'd3;
  localparam logic [2:0] CMD_INTEN = 3'd4;

  // Classified operation kinds
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_BYTE  = 3'd1;
  localparam logic [2:0] OP_IDLE  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_MODE  = 3'd4;
  localparam logic [2:0] OP_INTEN = 3'd5;

  // Frame bytes
  localparam logic [7:0] FRAME_SYNC0 = 8'hAA;
  localparam logic [7:0] FRAME_SYNC1 = 8'h55;
  localparam logic [7:0] FRAME_END   = 8'h75;
  localparam logic [7:0] FCMD_TIME   = 8'h01;
  localparam logic [7:0] FCMD_MODE   = 8'h02;
  localparam logic [7:0] FCMD_INTEN  = 8'h03;

  // Frame result codes
  localparam logic [2:0] RES_NONE    = 3'd0;
  localparam logic [2:0] RES_TIME    = 3'd1;
  localparam logic [2:0] RES_MODE    = 3'd2;
  localparam logic [2:0] RES_INTEN   = 3'd3;
  localparam logic [2:0] RES_IGNORED = 3'd4;

  // Display settings
  localparam logic [7:0] MODE_AUTO     = 8'd1;
  localparam logic [7:0] MODE_TIME     = 8'd3;
  localparam logic [7:0] INTEN_DEFAULT = 8'd15;

  // Multiplicative inverse of 25 modulo 2^16, and the largest multiple quotient
  localparam logic [15:0] INV25   = 16'd23593;
  localparam logic [15:0] LIM25   = 16'd2621;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } op_t;

  // Gregorian leap year; divisibility by 25 via the odd-divisor inverse test
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] p;
    logic        d25;
    p   = y * INV25;
    d25 = (p <= LIM25);
    return ((y[3:0] == 4'd0) && d25) || ((y[1:0] == 2'd0) && !d25);
  endfunction

  // Days in month; anything outside 1..12 counts as 30
  function automatic logic [4:0] month_days(input logic [7:0] m, input logic leap);
    logic [4:0] d;
    d = 5'd30;
    if (m == 8'd1 || m == 8'd3 || m == 8'd5 || m == 8'd7 || m == 8'd8 ||
        m == 8'd10 || m == 8'd12) begin
      d = 5'd31;
    end else if (m == 8'd2) begin
      d = leap ? 5'd29 : 5'd28;
    end
    return d;
  endfunction

endpackage

// ----- rtl/rtc_cal_front.sv -----
// Front end: accepts input words and classifies them into operations.
module rtc_cal_front import rtc_cal_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [7:0] rx_byte,
  output logic       push,
  output op_t        push_op,
  input  logic       q_ready
);

  logic fv;
  op_t  op;
  op_t  op_next;

  // Decode the event code; unused codes become no-ops
  always_comb begin
    op_next.data = 8'h00;
    unique case (cmd)
      CMD_BYTE: begin
        op_next.kind = OP_BYTE;
        op_next.data = rx_byte;
      end
      CMD_IDLE:  op_next.kind = OP_IDLE;
      CMD_TICK:  op_next.kind = OP_TICK;
      CMD_MODE:  op_next.kind = OP_MODE;
      CMD_INTEN: op_next.kind = OP_INTEN;
      default:   op_next.kind = OP_NONE;
    endcase
  end

  assign push     = fv && q_ready;
  assign push_op  = op;
  assign in_ready = !fv || q_ready;

  // Holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= op_next;
    end
  end

endmodule

// ----- rtl/rtc_cal_queue.sv -----
// Short operation queue between the front end and the back end.
module rtc_cal_queue import rtc_cal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output op_t  pop_op
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign pop_op  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// ----- rtl/rtc_cal_back.sv -----
// Back end: frame capture, clock cascade, display settings and result register.
module rtc_cal_back import rtc_cal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  op_t         pop_op,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  hour_out,
  output logic [7:0]  minute_out,
  output logic [7:0]  second_out,
  output logic [7:0]  day_out,
  output logic [7:0]  month_out,
  output logic [15:0] year_out,
  output logic [7:0]  display_mode,
  output logic [7:0]  intensity,
  output logic [2:0]  frame_result
);

  logic [7:0]       frame_head [HEAD_LEN];
  logic [7:0]       frame_head_next [HEAD_LEN];
  logic [7:0]       last_stored_byte, last_stored_byte_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       hour_reg, hour_reg_next;
  logic [7:0]       minute_reg, minute_reg_next;
  logic [7:0]       second_reg, second_reg_next;
  logic [7:0]       day_reg, day_reg_next;
  logic [7:0]       month_reg, month_reg_next;
  logic [15:0]      year_reg, year_reg_next;
  logic [7:0]       mode_reg, mode_reg_next;
  logic [7:0]       intensity_reg, intensity_reg_next;
  logic [2:0]       res;

  // Tick cascade terms
  logic [7:0]  s_inc, m_inc, h_inc, d_inc, mo_inc;
  logic        c_s, c_m, c_h, c_d, c_mo;
  logic [7:0]  t_sec, t_min, t_hour, t_day, t_month;
  logic [15:0] t_year;
  logic        frame_ok;

  assign pop = q_valid && (!out_valid || out_ready);

  // One-second advance, each field checked in turn on its updated value
  always_comb begin
    s_inc   = (second_reg < 8'd60) ? second_reg + 8'd1 : second_reg;
    c_s     = (s_inc == 8'd60);
    t_sec   = c_s ? 8'd0 : s_inc;
    m_inc   = c_s ? minute_reg + 8'd1 : minute_reg;
    c_m     = (m_inc == 8'd60);
    t_min   = c_m ? 8'd0 : m_inc;
    h_inc   = c_m ? hour_reg + 8'd1 : hour_reg;
    c_h     = (h_inc == 8'd24);
    t_hour  = c_h ? 8'd0 : h_inc;
    d_inc   = c_h ? day_reg + 8'd1 : day_reg;
    c_d     = (d_inc > {3'b000, month_days(month_reg, is_leap(year_reg))});
    t_day   = c_d ? 8'd1 : d_inc;
    mo_inc  = c_d ? month_reg + 8'd1 : month_reg;
    c_mo    = (mo_inc > 8'd12);
    t_month = c_mo ? 8'd1 : mo_inc;
    t_year  = c_mo ? year_reg + 16'd1 : year_reg;
  end

  assign frame_ok = (byte_count != '0) && (frame_head[0] == FRAME_SYNC0) &&
                    (frame_head[1] == FRAME_SYNC1) && (last_stored_byte == FRAME_END);

  // Execute one operation
  always_comb begin
    frame_head_next       = frame_head;
    last_stored_byte_next = last_stored_byte;
    byte_count_next       = byte_count;
    hour_reg_next         = hour_reg;
    minute_reg_next       = minute_reg;
    second_reg_next       = second_reg;
    day_reg_next          = day_reg;
    month_reg_next        = month_reg;
    year_reg_next         = year_reg;
    mode_reg_next         = mode_reg;
    intensity_reg_next    = intensity_reg;
    res                   = RES_NONE;
    unique case (pop_op.kind)
      OP_BYTE: begin
        // first byte of a frame clears the head buffer
        if (byte_count == '0) begin
          for (int i = 0; i < HEAD_LEN; i++) begin
            frame_head_next[i] = 8'h00;
          end
        end
        if (byte_count < RX_DEPTH) begin
          for (int i = 0; i < HEAD_LEN; i++) begin
            if (byte_count == CNT_W'(i)) begin
              frame_head_next[i] = pop_op.data;
            end
          end
          last_stored_byte_next = pop_op.data;
          byte_count_next       = byte_count + CNT_W'(1);
        end
      end
      OP_IDLE: begin
        res             = RES_IGNORED;
        byte_count_next = '0;
        if (frame_ok) begin
          priority if (frame_head[2] == FCMD_TIME) begin
            hour_reg_next   = frame_head[3];
            minute_reg_next = frame_head[4];
            second_reg_next = frame_head[5];
            day_reg_next    = frame_head[6];
            month_reg_next  = frame_head[7];
            year_reg_next   = {frame_head[8], frame_head[9]};
            res             = RES_TIME;
          end else if (frame_head[2] == FCMD_MODE) begin
            mode_reg_next = frame_head[3];
            res           = RES_MODE;
          end else if (frame_head[2] == FCMD_INTEN) begin
            intensity_reg_next = frame_head[3];
            res                = RES_INTEN;
          end else begin
            res = RES_IGNORED;
          end
        end
      end
      OP_TICK: begin
        second_reg_next = t_sec;
        minute_reg_next = t_min;
        hour_reg_next   = t_hour;
        day_reg_next    = t_day;
        month_reg_next  = t_month;
        year_reg_next   = t_year;
      end
      OP_MODE: begin
        if (mode_reg < MODE_TIME) begin
          mode_reg_next = mode_reg + 8'd1;
        end else if (mode_reg == MODE_TIME) begin
          mode_reg_next = MODE_AUTO;
        end
      end
      OP_INTEN: begin
        intensity_reg_next = (intensity_reg > 8'd1) ? intensity_reg - 8'd3 : INTEN_DEFAULT;
      end
      default: begin
      end
    endcase
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEAD_LEN; i++) begin
        frame_head[i] <= 8'h00;
      end
      last_stored_byte <= 8'h00;
      byte_count       <= '0;
      hour_reg         <= 8'd0;
      minute_reg       <= 8'd0;
      second_reg       <= 8'd0;
      day_reg          <= 8'd1;
      month_reg        <= 8'd1;
      year_reg         <= 16'd1971;
      mode_reg         <= MODE_AUTO;
      intensity_reg    <= INTEN_DEFAULT;
    end else if (pop) begin
      frame_head       <= frame_head_next;
      last_stored_byte <= last_stored_byte_next;
      byte_count       <= byte_count_next;
      hour_reg         <= hour_reg_next;
      minute_reg       <= minute_reg_next;
      second_reg       <= second_reg_next;
      day_reg          <= day_reg_next;
      month_reg        <= month_reg_next;
      year_reg         <= year_reg_next;
      mode_reg         <= mode_reg_next;
      intensity_reg    <= intensity_reg_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hour_out     <= hour_reg_next;
      minute_out   <= minute_reg_next;
      second_out   <= second_reg_next;
      day_out      <= day_reg_next;
      month_out    <= month_reg_next;
      year_out     <= year_reg_next;
      display_mode <= mode_reg_next;
      intensity    <= intensity_reg_next;
      frame_result <= res;
    end
  end

endmodule

// ----- rtl/framed_command_rtc_calendar.sv -----
// An accepted word passes the front register, a queue slot and the result
// register, in that order, before its result word is shown. Throughput: one word
// per cycle while neither side stalls; the front register and a four-entry queue
// let input and output stall independently, the result register holds one word.
// Reset (synchronous, active high): 00:00:00 on day 1, month 1, year 1971,
// display mode 1, intensity 15, frame buffer and queue empty.
module framed_command_rtc_calendar import rtc_cal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  hour_out,
  output logic [7:0]  minute_out,
  output logic [7:0]  second_out,
  output logic [7:0]  day_out,
  output logic [7:0]  month_out,
  output logic [15:0] year_out,
  output logic [7:0]  display_mode,
  output logic [7:0]  intensity,
  output logic [2:0]  frame_result
);

  logic push;
  op_t  push_op;
  logic q_ready;
  logic pop;
  logic q_valid;
  op_t  pop_op;

  rtc_cal_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .rx_byte  (rx_byte),
    .push     (push),
    .push_op  (push_op),
    .q_ready  (q_ready)
  );

  rtc_cal_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .pop_op  (pop_op)
  );

  rtc_cal_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .pop_op       (pop_op),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hour_out     (hour_out),
    .minute_out   (minute_out),
    .second_out   (second_out),
    .day_out      (day_out),
    .month_out    (month_out),
    .year_out     (year_out),
    .display_mode (display_mode),
    .intensity    (intensity),
    .frame_result (frame_result)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the framed command calendar clock.
`timescale 1ns / 100ps

module testbench;
  import rtc_cal_pkg::*;

  // Highest event code the three-bit field can carry
  localparam logic [2:0] CMD_LAST = 3'd7;

  typedef struct {
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  sec;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] year;
    logic [7:0]  mode;
    logic [7:0]  inten;
    logic [2:0]  res;
  } cal_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = CMD_BYTE;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  hour_out;
  logic [7:0]  minute_out;
  logic [7:0]  second_out;
  logic [7:0]  day_out;
  logic [7:0]  month_out;
  logic [15:0] year_out;
  logic [7:0]  display_mode;
  logic [7:0]  intensity;
  logic [2:0]  frame_result;

  framed_command_rtc_calendar dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .hour_out(hour_out), .minute_out(minute_out), .second_out(second_out),
    .day_out(day_out), .month_out(month_out), .year_out(year_out),
    .display_mode(display_mode), .intensity(intensity), .frame_result(frame_result)
  );

  // Predicted calendar and frame state
  logic [7:0]  head_bytes [HEAD_LEN];
  logic [7:0]  last_rx;
  int          rx_count;
  logic [7:0]  c_hour, c_min, c_sec, c_day, c_month, c_mode, c_inten;
  logic [15:0] c_year;

  cal_word_t   pending_words [$];
  logic [7:0]  frame_bytes [$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int time_sets = 0, mode_sets = 0, inten_sets = 0, frames_ignored = 0;
  int month_turns = 0;
  int tx_idle_pct = 38;
  int rx_idle_pct = 38;
  int hold_request = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Days in a month, Gregorian leap years; out-of-range months have 30
  function automatic int days_in(input logic [7:0] m, input logic [15:0] y);
    int unsigned yy;
    bit          leap;
    yy   = y;
    leap = (yy % 400 == 0) || ((yy % 4 == 0) && (yy % 100 != 0));
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 31;
      8'd2: return leap ? 29 : 28;
      default: return 30;
    endcase
  endfunction

  function automatic void reset_calendar();
    foreach (head_bytes[i]) head_bytes[i] = 8'd0;
    last_rx  = 8'd0;
    rx_count = 0;
    c_hour = 8'd0; c_min = 8'd0; c_sec = 8'd0;
    c_day = 8'd1; c_month = 8'd1; c_year = 16'd1971;
    c_mode = MODE_AUTO; c_inten = INTEN_DEFAULT;
  endfunction

  // Advance the predicted state by one event and return the word it shows
  function automatic cal_word_t apply_event(input logic [2:0] c, input logic [7:0] b);
    cal_word_t w;
    logic [2:0] res;
    res = RES_NONE;
    case (c)
      CMD_BYTE: begin
        if (rx_count == 0) foreach (head_bytes[i]) head_bytes[i] = 8'd0;
        if (rx_count < int'(RX_DEPTH)) begin
          if (rx_count < HEAD_LEN) head_bytes[rx_count] = b;
          last_rx = b;
          rx_count++;
        end
      end
      CMD_IDLE: begin
        res = RES_IGNORED;
        if (rx_count != 0 && head_bytes[0] == FRAME_SYNC0 && head_bytes[1] == FRAME_SYNC1 &&
            last_rx == FRAME_END) begin
          if (head_bytes[2] == FCMD_TIME) begin
            c_hour  = head_bytes[3];
            c_min   = head_bytes[4];
            c_sec   = head_bytes[5];
            c_day   = head_bytes[6];
            c_month = head_bytes[7];
            c_year  = {head_bytes[8], head_bytes[9]};
            res = RES_TIME;
          end else if (head_bytes[2] == FCMD_MODE) begin
            c_mode = head_bytes[3];
            res = RES_MODE;
          end else if (head_bytes[2] == FCMD_INTEN) begin
            c_inten = head_bytes[3];
            res = RES_INTEN;
          end
        end
        rx_count = 0;
        case (res)
          RES_TIME:  time_sets++;
          RES_MODE:  mode_sets++;
          RES_INTEN: inten_sets++;
          default:   frames_ignored++;
        endcase
      end
      CMD_TICK: begin
        // seconds, minutes and hours cascade on equality, days and months on overflow; seconds only count below 60
        if (c_sec < 8'd60) c_sec++;
        if (c_sec == 8'd60) begin
          c_sec = 8'd0;
          c_min++;
        end
        if (c_min == 8'd60) begin
          c_min = 8'd0;
          c_hour++;
        end
        if (c_hour == 8'd24) begin
          c_hour = 8'd0;
          c_day++;
        end
        if (int'(c_day) > days_in(c_month, c_year)) begin
          c_day = 8'd1;
          c_month++;
          month_turns++;
        end
        if (c_month > 8'd12) begin
          c_month = 8'd1;
          c_year++;
        end
      end
      CMD_MODE: begin
        if (c_mode < MODE_TIME) c_mode++;
        else if (c_mode == MODE_TIME) c_mode = MODE_AUTO;
      end
      CMD_INTEN: begin
        if (c_inten > 8'd1) c_inten = c_inten - 8'd3;
        else c_inten = INTEN_DEFAULT;
      end
      default: ;
    endcase
    w.hour = c_hour; w.minute = c_min; w.sec = c_sec;
    w.day = c_day; w.month = c_month; w.year = c_year;
    w.mode = c_mode; w.inten = c_inten; w.res = res;
    return w;
  endfunction

  // Offer one word, with random idle cycles first, and record its prediction
  task automatic send_word(input logic [2:0] c, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_words.push_back(apply_event(c, b));
    words_sent++;
  endtask

  // Send the collected frame bytes, then the line idle that closes the frame
  task automatic send_frame();
    foreach (frame_bytes[i]) send_word(CMD_BYTE, frame_bytes[i]);
    send_word(CMD_IDLE, 8'($urandom));
    frame_bytes.delete();
  endtask

  task automatic start_frame(input logic [7:0] fc, input logic [7:0] v);
    frame_bytes.push_back(FRAME_SYNC0);
    frame_bytes.push_back(FRAME_SYNC1);
    frame_bytes.push_back(fc);
    frame_bytes.push_back(v);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Result side: check each word and drive ready with random stalls
  function automatic void compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    cal_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        w = pending_words.pop_front();
        compare_field("hour_out", w.hour, hour_out);
        compare_field("minute_out", w.minute, minute_out);
        compare_field("second_out", w.sec, second_out);
        compare_field("day_out", w.day, day_out);
        compare_field("month_out", w.month, month_out);
        compare_field("year_out", w.year, year_out);
        compare_field("display_mode", w.mode, display_mode);
        compare_field("intensity", w.inten, intensity);
        compare_field("frame_result", w.res, frame_result);
        words_checked++;
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_request - 1;
      hold_request = 0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Reset state, unused codes, buttons around their wrap, short and bad frames
  task automatic test_directed();
    send_word(CMD_IDLE, 8'hFF);
    for (int c = int'(CMD_INTEN) + 1; c <= int'(CMD_LAST); c++) send_word(3'(c), 8'h00);
    repeat (3) send_word(CMD_MODE, 8'hFF);
    repeat (6) send_word(CMD_INTEN, 8'h00);
    // short time frame: unreceived fields read as zero
    frame_bytes.push_back(FRAME_SYNC0);
    frame_bytes.push_back(FRAME_SYNC1);
    frame_bytes.push_back(FCMD_TIME);
    frame_bytes.push_back(FRAME_END);
    send_frame();
    send_word(CMD_TICK, 8'hFF);
    // unknown frame command
    frame_bytes.push_back(FRAME_SYNC0);
    frame_bytes.push_back(FRAME_SYNC1);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(FRAME_END);
    send_frame();
    // bad sync
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(FRAME_END);
    send_frame();
  endtask

  // Time set near the rollover points, then a run of ticks
  task automatic test_calendar(input int rounds);
    logic [7:0]  h, m, s, d, mo;
    logic [15:0] y;
    repeat (rounds) begin
      case ($urandom_range(6))
        0: y = 16'd2000;
        1: y = 16'd1900;
        2: y = 16'd2024;
        3: y = 16'd2023;
        4: y = 16'hFFFF;
        5: y = 16'd2100;
        default: y = 16'($urandom);
      endcase
      if ($urandom_range(7) == 0) mo = 8'($urandom);
      else if ($urandom_range(2) == 0) mo = 8'd2;
      else mo = 8'($urandom_range(12, 1));
      case ($urandom_range(5))
        0: d = 8'($urandom);
        1: d = 8'(days_in(mo, y) - 1);
        default: d = 8'(days_in(mo, y));
      endcase
      h = ($urandom_range(5) == 0) ? 8'($urandom) : 8'd23;
      m = ($urandom_range(5) == 0) ? 8'($urandom) : 8'd59;
      s = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(59, 40));
      start_frame(FCMD_TIME, h);
      frame_bytes.push_back(m);
      frame_bytes.push_back(s);
      frame_bytes.push_back(d);
      frame_bytes.push_back(mo);
      frame_bytes.push_back(y[15:8]);
      frame_bytes.push_back(y[7:0]);
      repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(FRAME_END);
      send_frame();
      repeat ($urandom_range(60, 1)) send_word(CMD_TICK, 8'($urandom));
      if ($urandom_range(3) == 0) send_word(3'($urandom_range(CMD_INTEN, CMD_MODE)), 8'($urandom));
    end
  endtask

  // Mode and intensity frames with random content, plus broken frames
  task automatic test_frames(input int rounds);
    int         kind;
    logic [7:0] v, fc;
    repeat (rounds) begin
      kind = $urandom_range(9);
      v  = ($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'($urandom);
      fc = 8'($urandom_range(FCMD_INTEN, FCMD_TIME));
      case (kind)
        0, 1: begin
          if ($urandom_range(2) != 0) v = 8'($urandom_range(MODE_TIME, MODE_AUTO));
          start_frame(FCMD_MODE, v);
        end
        2, 3: start_frame(FCMD_INTEN, v);
        4: begin
          fc = 8'($urandom);
          if (fc >= FCMD_TIME && fc <= FCMD_INTEN) fc = fc + 8'd4;
          start_frame(fc, v);
        end
        5: begin
          start_frame(fc, v);
          frame_bytes[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
        end
        6: start_frame(fc, v);
        7: begin
          // short frame, possibly just the end byte
          start_frame(fc, v);
          kind = $urandom_range(3);
          while (frame_bytes.size() > kind) void'(frame_bytes.pop_back());
        end
        8: begin
          // overflow: bytes past the buffer depth are dropped
          start_frame(fc, v);
          while (frame_bytes.size() < int'(RX_DEPTH) - 1) frame_bytes.push_back(8'($urandom));
          frame_bytes.push_back(($urandom_range(2) != 0) ? FRAME_END : 8'($urandom));
          repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom));
          if ($urandom_range(1) == 0) frame_bytes.push_back(FRAME_END);
          kind = 9;
        end
        default: ;
      endcase
      if (kind <= 5) begin
        repeat ($urandom_range(4)) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(FRAME_END);
      end else if (kind == 6) begin
        v = 8'($urandom);
        if (v == FRAME_END) v = v ^ 8'h01;
        frame_bytes.push_back(v);
      end else if (kind <= 3) begin
        frame_bytes.push_back(FRAME_END);
      end
      send_frame();
      repeat ($urandom_range(3)) send_word(3'($urandom_range(CMD_INTEN, CMD_TICK)), 8'($urandom));
    end
  endtask

  // Unstructured events, biased towards the frame marker bytes
  task automatic test_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(7))
        0: b = FRAME_SYNC0;
        1: b = FRAME_SYNC1;
        2: b = FRAME_END;
        3: b = 8'($urandom_range(FCMD_INTEN, FCMD_TIME));
        default: b = 8'($urandom);
      endcase
      send_word(3'($urandom_range(CMD_LAST)), b);
    end
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_request = 300;
    repeat (3) begin
      start_frame(FCMD_INTEN, 8'($urandom));
      frame_bytes.push_back(FRAME_END);
      send_frame();
    end
    repeat (25) send_word(CMD_TICK, 8'($urandom));
    await_results();
    tx_idle_pct = 38;
  endtask

  // Stretch with no idling on either side
  task automatic test_streaming();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_frames(20);
    test_calendar(3);
    tx_idle_pct = 38;
    rx_idle_pct = 38;
  endtask

  initial begin
    reset_calendar();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_calendar(9);
    await_results();
    test_frames(35);
    test_noise(120);
    test_streaming();
    test_backpressure();
    test_frames(10);
    await_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d words, %0d results checked, %0d month rollovers.",
             words_sent, words_checked, month_turns);
    $display("Frames: %0d time, %0d mode, %0d intensity set, %0d ignored.",
             time_sets, mode_sets, inten_sets, frames_ignored);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
